@@ rtl/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TIMERS      = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int MODE_W  = 4;
  localparam int INDEX_W = 4;
  localparam int OUT_CW  = 32;
  localparam int STATE_W = 2;

  // timer address width, at least one bit
  localparam int ADDR_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int ENTRY_W = COUNT_WIDTH + STATE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 4'd0,
    MODE_START     = 4'd1,
    MODE_STOP      = 4'd2,
    MODE_CLEAR     = 4'd3,
    MODE_PAUSE     = 4'd4,
    MODE_RESUME    = 4'd5,
    MODE_READ      = 4'd6,
    MODE_STOP_ALL  = 4'd7,
    MODE_START_ALL = 4'd8
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_PAUSED  = 2'd2
  } tstate_t;

  // one bank entry as held in the RAM
  typedef struct packed {
    tstate_t                st;
    logic [COUNT_WIDTH-1:0] cnt;
  } entry_t;

  // request to the update unit
  typedef struct packed {
    cmd_t   cmd;
    entry_t cur;
  } upd_req_t;

  // answer of the update unit
  typedef struct packed {
    logic   we;
    entry_t nxt;
  } upd_rsp_t;

endpackage

@@ rtl/stb_ram.sv @@
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/stb_update.sv @@
// ----------------------------------------------------------------------------
// stb_update
// Shared update unit: applies one command to one timer entry.
// ----------------------------------------------------------------------------
module stb_update (
  input  stb_pkg::upd_req_t req,
  output stb_pkg::upd_rsp_t rsp
);

  always_comb begin
    rsp.we  = 1'b1;
    rsp.nxt = req.cur;
    case (req.cmd)
      stb_pkg::MODE_TICK: begin
        rsp.we = (req.cur.st == stb_pkg::TS_RUNNING);
        rsp.nxt.cnt = req.cur.cnt + stb_pkg::COUNT_WIDTH'(1);  // wraps
      end
      stb_pkg::MODE_START: begin
        rsp.we = (req.cur.st == stb_pkg::TS_STOPPED);
        rsp.nxt.cnt = '0;
        rsp.nxt.st  = stb_pkg::TS_RUNNING;
      end
      stb_pkg::MODE_STOP,
      stb_pkg::MODE_STOP_ALL: begin
        rsp.nxt.st = stb_pkg::TS_STOPPED;
      end
      stb_pkg::MODE_CLEAR: begin
        rsp.nxt.cnt = '0;
      end
      stb_pkg::MODE_PAUSE: begin
        rsp.we = (req.cur.st == stb_pkg::TS_RUNNING);
        rsp.nxt.st = stb_pkg::TS_PAUSED;
      end
      stb_pkg::MODE_RESUME: begin
        rsp.we = (req.cur.st == stb_pkg::TS_PAUSED);
        rsp.nxt.st = stb_pkg::TS_RUNNING;
      end
      stb_pkg::MODE_START_ALL: begin
        rsp.nxt.cnt = '0;
        rsp.nxt.st  = stb_pkg::TS_RUNNING;
      end
      default: begin
        // read and unused codes leave the entry alone
        rsp.we = 1'b0;
      end
    endcase
    if (!rsp.we) begin
      rsp.nxt = req.cur;
    end
  end

endmodule

@@ rtl/software_timer_bank.sv @@
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of elapsed-time counters, each stopped, running or paused, kept in
// one RAM and updated one entry per cycle by a shared update unit.
// ----------------------------------------------------------------------------
//
//  channel | ports                                                  | role
//  --------+--------------------------------------------------------+------------
//  in      | in_valid, in_stall, in_mode, in_timer_index            | command in
//  out     | out_valid, out_stall, out_count_value, out_timer_state | result out
//
//  Tick, stop all and start all sweep the whole bank: read-modify-write of
//  one entry per cycle through the RAM.
//  Single-timer commands take one entry pass; a command with an index
//  beyond the bank skips the RAM and reports zeros.
//  Reset clears a per-entry valid bit; an entry never written reads as count
//  zero, stopped, so no clearing pass is needed.
//  A new command is taken while the previous result still waits in the
//  output register; out_stall only holds the finished result back.
// ----------------------------------------------------------------------------
module software_timer_bank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [stb_pkg::MODE_W-1:0]  in_mode,
  input  logic [stb_pkg::INDEX_W-1:0] in_timer_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stb_pkg::OUT_CW-1:0]  out_count_value,
  output logic [stb_pkg::STATE_W-1:0] out_timer_state
);

  localparam int AW = stb_pkg::ADDR_W;
  localparam int CW = stb_pkg::COUNT_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // sequencer
  state_t                 state_r, state_nxt;
  stb_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0]          tgt_r, tgt_nxt;       // addressed timer
  logic                   tvld_r, tvld_nxt;     // index inside the bank
  logic                   sweep_r, sweep_nxt;   // whole-bank command
  logic [AW:0]            rd_cnt_r, rd_cnt_nxt; // reads issued so far
  logic                   pend_r, pend_nxt;     // read data due this cycle
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;
  stb_pkg::entry_t        res_r, res_nxt;       // result being built
  logic [stb_pkg::TIMERS-1:0] vld_r, vld_nxt;   // entry has been written

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [stb_pkg::OUT_CW-1:0]  out_cnt_r, out_cnt_nxt;
  logic [stb_pkg::STATE_W-1:0] out_st_r, out_st_nxt;

  // RAM and update unit
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [stb_pkg::ENTRY_W-1:0]  ram_rdata;
  stb_pkg::upd_req_t            upd_req;
  stb_pkg::upd_rsp_t            upd_rsp;
  logic                         ram_we;

  // decode of the incoming item
  logic [AW+stb_pkg::INDEX_W-1:0] idx_ext;
  logic                           in_idx_ok;
  stb_pkg::cmd_t                  in_cmd;
  logic                           in_sweep;
  logic [AW:0]                    rd_n;
  logic [CW+stb_pkg::OUT_CW-1:0]  cnt_ext;

  assign idx_ext   = {{AW{1'b0}}, in_timer_index};
  assign in_idx_ok = idx_ext < (AW + stb_pkg::INDEX_W)'(stb_pkg::TIMERS);
  assign in_cmd    = stb_pkg::cmd_t'(in_mode);
  assign in_sweep  = (in_cmd == stb_pkg::MODE_TICK) ||
                     (in_cmd == stb_pkg::MODE_STOP_ALL) ||
                     (in_cmd == stb_pkg::MODE_START_ALL);

  // a sweep reads every entry, a single command only its target
  assign rd_n      = sweep_r ? (AW+1)'(stb_pkg::TIMERS) : (AW+1)'(1);

  assign in_stall  = (state_r != ST_IDLE);

  assign ram_re    = (state_r == ST_RUN) && (rd_cnt_r < rd_n);
  assign ram_raddr = sweep_r ? rd_cnt_r[AW-1:0] : tgt_r;

  // entries never written hold the reset value
  always_comb begin
    upd_req.cmd = cmd_r;
    if (vld_r[pend_addr_r]) begin
      upd_req.cur = stb_pkg::entry_t'(ram_rdata);
    end else begin
      upd_req.cur.st  = stb_pkg::TS_STOPPED;
      upd_req.cur.cnt = '0;
    end
  end

  stb_update u_update (
    .req (upd_req),
    .rsp (upd_rsp)
  );

  assign ram_we = pend_r && upd_rsp.we;

  stb_ram #(
    .WIDTH (stb_pkg::ENTRY_W),
    .DEPTH (stb_pkg::TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_addr_r),
    .wdata (upd_rsp.nxt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_ext = {{stb_pkg::OUT_CW{1'b0}}, res_r.cnt};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    tvld_nxt      = tvld_r;
    sweep_nxt     = sweep_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    res_nxt       = res_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;

    // result leaves the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          tgt_nxt     = idx_ext[AW-1:0];
          tvld_nxt    = in_idx_ok;
          sweep_nxt   = in_sweep;
          rd_cnt_nxt  = '0;
          res_nxt.st  = stb_pkg::TS_STOPPED;
          res_nxt.cnt = '0;
          // single command on a missing timer: nothing to touch
          state_nxt   = (in_sweep || in_idx_ok) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (ram_re) begin
          rd_cnt_nxt    = rd_cnt_r + (AW+1)'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = ram_raddr;
        end
        if (pend_r) begin
          if (ram_we) begin
            vld_nxt[pend_addr_r] = 1'b1;
          end
          if (tvld_r && (pend_addr_r == tgt_r)) begin
            res_nxt = upd_rsp.nxt;
          end
          if (!ram_re) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_ext[stb_pkg::OUT_CW-1:0];
          out_st_nxt    = res_r.st;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    tgt_r       <= tgt_nxt;
    tvld_r      <= tvld_nxt;
    sweep_r     <= sweep_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_cnt_r;
  assign out_timer_state = out_st_r;

  // ---------------------------------------------------------------- checks

  // a command transfer blocks the input until its result is built
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a command transfer");

  // a new result appears only out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  // RAM is written only with read data in hand
  a_write_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> pend_r && (state_r == ST_RUN))
    else $error("RAM write without pending read data");

  // the read counter never overruns its pass
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rd_cnt_r <= rd_n))
    else $error("read counter beyond the pass length");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for software_timer_bank. It drives commands and checks every
// result against a cycle-free copy of the bank's counts and run states.
// ----------------------------------------------------------------------------
module tb;

  // one result transfer: the addressed timer after the command
  typedef struct {
    logic [stb_pkg::OUT_CW-1:0] cnt;
    stb_pkg::tstate_t           st;
  } timer_view_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [stb_pkg::MODE_W-1:0]   in_mode = '0;
  logic [stb_pkg::INDEX_W-1:0]  in_timer_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [stb_pkg::OUT_CW-1:0]   out_count_value;
  logic [stb_pkg::STATE_W-1:0]  out_timer_state;

  // predicted bank contents, updated when a command transfer is accepted
  logic [stb_pkg::COUNT_WIDTH-1:0] bank_cnt [stb_pkg::TIMERS];
  stb_pkg::tstate_t                bank_st  [stb_pkg::TIMERS];

  // results still to come out, oldest first
  timer_view_t pending_views [$];

  int  err_cnt   = 0;
  int  n_sent    = 0;
  int  idle_pct  = 0;   // sender gap chance, percent per cycle
  int  stall_pct = 0;   // receiver stall chance, percent per cycle
  logic long_hold = 1'b0;
  event hold_go;

  software_timer_bank u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_timer_index  (in_timer_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count_value (out_count_value),
    .out_timer_state (out_timer_state)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bank predictor: applies one command, returns the addressed timer's view.
  // Undefined modes fall through to a plain read. An index past the bank
  // reports zeros (unreachable while TIMERS fills the index field).
  // --------------------------------------------------------------------------
  function automatic timer_view_t step_bank(input logic [stb_pkg::MODE_W-1:0] mode,
                                            input logic [stb_pkg::INDEX_W-1:0] idx);
    timer_view_t v;
    bit          hit;
    int          t;
    hit = (int'(idx) < stb_pkg::TIMERS);
    t   = hit ? int'(idx) : 0;
    case (mode)
      stb_pkg::MODE_TICK: begin
        for (int k = 0; k < stb_pkg::TIMERS; k++)
          if (bank_st[k] == stb_pkg::TS_RUNNING) bank_cnt[k] = bank_cnt[k] + 1'b1;
      end
      stb_pkg::MODE_START: begin
        if (hit && bank_st[t] == stb_pkg::TS_STOPPED) begin
          bank_cnt[t] = '0;
          bank_st[t]  = stb_pkg::TS_RUNNING;
        end
      end
      stb_pkg::MODE_STOP: begin
        if (hit) bank_st[t] = stb_pkg::TS_STOPPED;
      end
      stb_pkg::MODE_CLEAR: begin
        if (hit) bank_cnt[t] = '0;
      end
      stb_pkg::MODE_PAUSE: begin
        if (hit && bank_st[t] == stb_pkg::TS_RUNNING) bank_st[t] = stb_pkg::TS_PAUSED;
      end
      stb_pkg::MODE_RESUME: begin
        if (hit && bank_st[t] == stb_pkg::TS_PAUSED) bank_st[t] = stb_pkg::TS_RUNNING;
      end
      stb_pkg::MODE_STOP_ALL: begin
        for (int k = 0; k < stb_pkg::TIMERS; k++) bank_st[k] = stb_pkg::TS_STOPPED;
      end
      stb_pkg::MODE_START_ALL: begin
        for (int k = 0; k < stb_pkg::TIMERS; k++) begin
          bank_cnt[k] = '0;
          bank_st[k]  = stb_pkg::TS_RUNNING;
        end
      end
      default: ;  // read and undefined modes change nothing
    endcase
    if (hit) begin
      v.cnt = bank_cnt[t][stb_pkg::OUT_CW-1:0];
      v.st  = bank_st[t];
    end else begin
      v.cnt = '0;
      v.st  = stb_pkg::TS_STOPPED;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Send one command. Gaps come before valid rises; once up, valid and the
  // payload hold until the transfer at an edge with in_stall low.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [stb_pkg::MODE_W-1:0] mode,
                          input logic [stb_pkg::INDEX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_timer_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_views.push_back(step_bank(mode, idx));
    n_sent++;
  endtask

  // weighted command mix; the tail draws any 4-bit code, undefined ones too
  function automatic logic [stb_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 30) return stb_pkg::MODE_TICK;
    if (r < 40) return stb_pkg::MODE_START;
    if (r < 48) return stb_pkg::MODE_STOP;
    if (r < 55) return stb_pkg::MODE_CLEAR;
    if (r < 63) return stb_pkg::MODE_PAUSE;
    if (r < 71) return stb_pkg::MODE_RESUME;
    if (r < 80) return stb_pkg::MODE_READ;
    if (r < 85) return stb_pkg::MODE_STOP_ALL;
    if (r < 90) return stb_pkg::MODE_START_ALL;
    return stb_pkg::MODE_W'($urandom_range(15));
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: each transfer out is matched against the oldest
  // prediction. Outputs are sampled at the edge, before the block updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : chk_result
    timer_view_t exp_v;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_views.size() == 0) begin
        $error("result transfer with nothing outstanding: count %0d state %0d",
               out_count_value, out_timer_state);
        err_cnt++;
      end else begin
        exp_v = pending_views.pop_front();
        if (out_count_value !== exp_v.cnt) begin
          $error("count_value: expected %0d, got %0d", exp_v.cnt, out_count_value);
          err_cnt++;
        end
        if (out_timer_state !== exp_v.st) begin
          $error("timer_state: expected %0d, got %0d", exp_v.st, out_timer_state);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, plus the long hold when one is running
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= long_hold || ($urandom_range(99) < stall_pct);
  end

  // long hold-off, counted here so the sender keeps offering meanwhile
  always begin
    @(hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // start/stop/pause/resume/clear on single timers, including the no-op cases
  task automatic test_single_timer_cmds();
    send_cmd(stb_pkg::MODE_READ, 4'd0);        // untouched timer reads zero, stopped
    send_cmd(stb_pkg::MODE_READ, 4'd15);
    send_cmd(stb_pkg::MODE_TICK, 4'd0);        // nothing running
    send_cmd(stb_pkg::MODE_START, 4'd0);
    send_cmd(stb_pkg::MODE_START, 4'd15);
    send_cmd(stb_pkg::MODE_TICK, 4'd15);
    send_cmd(stb_pkg::MODE_TICK, 4'd0);
    send_cmd(stb_pkg::MODE_START, 4'd0);       // already running: ignored
    send_cmd(stb_pkg::MODE_PAUSE, 4'd0);
    send_cmd(stb_pkg::MODE_TICK, 4'd0);        // paused timer holds
    send_cmd(stb_pkg::MODE_PAUSE, 4'd0);       // already paused: ignored
    send_cmd(stb_pkg::MODE_RESUME, 4'd15);     // running, not paused: ignored
    send_cmd(stb_pkg::MODE_RESUME, 4'd0);
    send_cmd(stb_pkg::MODE_STOP, 4'd15);
    send_cmd(stb_pkg::MODE_TICK, 4'd15);
    send_cmd(stb_pkg::MODE_CLEAR, 4'd0);       // clear keeps it running
    send_cmd(stb_pkg::MODE_RESUME, 4'd15);     // stopped: ignored
  endtask

  // whole-bank commands
  task automatic test_bank_cmds();
    send_cmd(stb_pkg::MODE_START_ALL, 4'd15);  // stopped timer restarts from zero
    send_cmd(stb_pkg::MODE_TICK, 4'd7);
    send_cmd(stb_pkg::MODE_STOP_ALL, 4'd0);    // counts stay
    send_cmd(stb_pkg::MODE_READ, 4'd7);
    send_cmd(stb_pkg::MODE_START_ALL, 4'd8);
  endtask

  // undefined command codes act as reads; counter wrap at 2^32 is beyond reach
  task automatic test_undefined_modes();
    send_cmd(4'd9, 4'd8);
    send_cmd(4'd15, 4'd0);
  endtask

  // random traffic: mostly timer lifecycles, the rest loose commands
  task automatic test_random_traffic(input int n_items, input int idle_p, input int stall_p);
    int          start_n;
    logic [3:0]  t;
    idle_pct  = idle_p;
    stall_pct = stall_p;
    start_n   = n_sent;
    while (n_sent - start_n < n_items) begin
      if ($urandom_range(99) < 70) begin
        t = 4'($urandom_range(15));
        send_cmd(stb_pkg::MODE_START, t);
        repeat ($urandom_range(1, 6)) send_cmd(stb_pkg::MODE_TICK, 4'($urandom_range(15)));
        if ($urandom_range(1)) begin
          send_cmd(stb_pkg::MODE_PAUSE, t);
          repeat ($urandom_range(0, 3)) send_cmd(stb_pkg::MODE_TICK, t);
          if ($urandom_range(1)) send_cmd(stb_pkg::MODE_RESUME, t);
        end
        send_cmd(stb_pkg::MODE_READ, t);
        if ($urandom_range(99) < 30) send_cmd(stb_pkg::MODE_STOP, t);
      end else begin
        repeat ($urandom_range(1, 4)) send_cmd(pick_mode(), 4'($urandom_range(15)));
      end
    end
  endtask

  // receiver holds off long enough that the block backs up its input
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    -> hold_go;
    repeat (40) send_cmd(pick_mode(), 4'($urandom_range(15)));
  endtask

  // wait for every outstanding result, then a little more for stragglers
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_views.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_views.size() != 0) begin
      $error("%0d result(s) never came out", pending_views.size());
      err_cnt++;
    end
  endtask

  initial begin
    for (int k = 0; k < stb_pkg::TIMERS; k++) begin
      bank_cnt[k] = '0;
      bank_st[k]  = stb_pkg::TS_STOPPED;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_timer_cmds();
    test_bank_cmds();
    test_undefined_modes();
    test_output_holdoff();
    test_random_traffic(445, 0, 0);
    test_random_traffic(445, 72, 0);
    test_random_traffic(445, 0, 72);
    test_random_traffic(445, 17, 17);

    in_valid  <= 1'b0;
    stall_pct = 0;
    drain_results();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
